// File: rtl/chaikin_corner_cutting_pass_defines.svh
// ============================================================================
// Chaikin pass assertion macros
// Shared property forms for the corner-cutting pass checks.
// ============================================================================
`ifndef CHAIKIN_CORNER_CUTTING_PASS_DEFINES_SVH
`define CHAIKIN_CORNER_CUTTING_PASS_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define CCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ccp_pkg.sv
// ============================================================================
// Chaikin pass package
// Register indexes and shared control types.
// ============================================================================
package ccp_pkg;

    localparam logic [1:0] REG_KEEP_ENDPOINTS = 2'd0;
    localparam logic [1:0] REG_CLOSE_RING     = 2'd1;
    localparam logic [1:0] REG_USE_Z          = 2'd2;
    localparam logic [1:0] REG_USE_M          = 2'd3;

    typedef struct packed {
        logic keep_endpoints;
        logic close_ring;
        logic use_z;
        logic use_m;
    } t_cfg;

    typedef struct packed {
        logic       can_load;
        logic       busy;
        logic [1:0] count;
    } t_q_stat;

endpackage

// File: rtl/ccp_cut.sv
// ============================================================================
// Chaikin cut lanes
// Quarter delta and the two cut points per coordinate, four lanes.
// ============================================================================
module ccp_cut #(
    parameter int W = 32
) (
    input  logic [3:0][W-1:0] i_prev,
    input  logic [3:0][W-1:0] i_cur,
    output logic [3:0][W-1:0] o_cut1,
    output logic [3:0][W-1:0] o_cut2
);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [W:0]   diff;
        logic [W-1:0] quarter;

        assign diff    = {i_cur[g][W-1], i_cur[g]} - {i_prev[g][W-1], i_prev[g]};
        assign quarter = {diff[W], diff[W:2]};
        assign o_cut1[g] = i_prev[g] + quarter;
        assign o_cut2[g] = i_cur[g] - quarter;
    end

endmodule

// File: rtl/ccp_outq.sv
// ============================================================================
// Chaikin result queue
// Three-slot result register, loaded per request, drained one per ready cycle.
// ============================================================================
module ccp_outq #(
    parameter int W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [2:0][3:0][W-1:0]  i_pts,
    input  logic [2:0]              i_last,
    input  logic [1:0]              i_cnt,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [3:0][W-1:0]       o_pt,
    output logic                    o_last,
    output ccp_pkg::t_q_stat        o_stat
);

    logic [2:0][3:0][W-1:0] r_pt;
    logic [2:0]             r_last;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;
    logic                   pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid & i_ready;
    assign o_pt    = r_pt[0];
    assign o_last  = r_last[0];

    assign o_stat.can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_stat.busy     = o_valid;
    assign o_stat.count    = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_cnt;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt   <= i_pts;
            r_last <= i_last;
        end else if (pop) begin
            r_pt[0]   <= r_pt[1];
            r_pt[1]   <= r_pt[2];
            r_last[0] <= r_last[1];
            r_last[1] <= r_last[2];
        end
    end

endmodule

// File: rtl/chaikin_corner_cutting_pass.sv
// ============================================================================
// Chaikin corner-cutting pass
// One corner-cutting pass over a stream of 4-D polyline points.
// ============================================================================
//  channel   direction  handshake             payload
//  s         in         i_s_tvalid/o_s_tready  tdata x,y,z,m; tlast end_of_line
//  m         out        o_m_tvalid/i_m_tready  tdata x,y,z,m; tlast out_last
//  apb       cfg        psel/penable/pready    4 one-bit registers at 4*i
//
//  A point is cut in the cycle it is taken; its zero to three results leave
//  the result queue one per cycle while i_m_tready is high.
//  The next point is taken in the cycle the queue's last result is taken.
//  Synchronous active-low reset clears polyline state and empties the queue.
//  A stall on the m side holds the queue and closes o_s_tready.
// ============================================================================
`include "chaikin_corner_cutting_pass_defines.svh"

module chaikin_corner_cutting_pass #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [x | y | z | m] from bit 0 up, each COORD_WIDTH, zero pad to bytes
    input  logic [((4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [out_x | out_y | out_z | out_m] from bit 0 up, zero pad to bytes
    output logic [((4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic                  o_m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int W       = COORD_WIDTH;
    localparam int TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8;

    ccp_pkg::t_cfg          r_cfg;
    ccp_pkg::t_cfg          n_cfg;
    ccp_pkg::t_q_stat       q_stat;

    logic [3:0][W-1:0]      r_prev;
    logic [3:0][W-1:0]      r_first;
    logic                   r_have_prev;
    logic                   r_prev_first;
    logic                   r_first_valid;
    logic                   n_have_prev;
    logic                   n_prev_first;
    logic                   n_first_valid;

    logic [3:0][W-1:0]      cur;
    logic [3:0][W-1:0]      cut1;
    logic [3:0][W-1:0]      cut2;
    logic                   eol;
    logic                   accept;
    logic                   cfg_wr;

    logic [3:0][W-1:0]      cand_a;
    logic [3:0][W-1:0]      cand_b;
    logic [3:0][W-1:0]      cand_c;
    logic                   en_a;
    logic                   en_b;
    logic                   en_c;
    logic [2:0][3:0][W-1:0] slot;
    logic [2:0]             slot_last;
    logic [1:0]             slot_cnt;
    logic [3:0][W-1:0]      q_pt;

    function automatic logic [3:0][W-1:0] mask_zm(input logic [3:0][W-1:0] pt,
                                                  input ccp_pkg::t_cfg cfg);
        logic [3:0][W-1:0] res;
        res    = pt;
        res[2] = cfg.use_z ? pt[2] : '0;
        res[3] = cfg.use_m ? pt[3] : '0;
        return res;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                ccp_pkg::REG_KEEP_ENDPOINTS: n_cfg.keep_endpoints = pwdata[0];
                ccp_pkg::REG_CLOSE_RING:     n_cfg.close_ring     = pwdata[0];
                ccp_pkg::REG_USE_Z:          n_cfg.use_z          = pwdata[0];
                ccp_pkg::REG_USE_M:          n_cfg.use_m          = pwdata[0];
                default:                     n_cfg                = r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            ccp_pkg::REG_KEEP_ENDPOINTS: prdata[0] = r_cfg.keep_endpoints;
            ccp_pkg::REG_CLOSE_RING:     prdata[0] = r_cfg.close_ring;
            ccp_pkg::REG_USE_Z:          prdata[0] = r_cfg.use_z;
            ccp_pkg::REG_USE_M:          prdata[0] = r_cfg.use_m;
            default:                     prdata    = '0;
        endcase
    end

    // input side
    assign cur        = i_s_tdata[4*W-1:0];
    assign eol        = i_s_tlast;
    assign o_s_tready = q_stat.can_load;
    assign accept     = i_s_tvalid & q_stat.can_load;

    ccp_cut #(
        .W (W)
    ) u_cut (
        .i_prev (r_prev),
        .i_cur  (cur),
        .o_cut1 (cut1),
        .o_cut2 (cut2)
    );

    // candidate results in emission order, then packed to the front
    always_comb begin
        if (r_have_prev) begin
            cand_a = cut1;
            cand_b = cut2;
            cand_c = r_cfg.keep_endpoints ? cur : (r_first_valid ? r_first : cut1);
            en_a   = !r_cfg.keep_endpoints || !r_prev_first;
            en_b   = !r_cfg.keep_endpoints || !eol;
            en_c   = eol && (r_cfg.keep_endpoints ||
                             (r_cfg.close_ring && (r_first_valid || en_a)));
        end else begin
            cand_a = cur;
            cand_b = cur;
            cand_c = cur;
            en_a   = r_cfg.keep_endpoints;
            en_b   = 1'b0;
            en_c   = r_cfg.keep_endpoints && eol;
        end
    end

    always_comb begin
        slot[0]  = mask_zm(en_a ? cand_a : (en_b ? cand_b : cand_c), r_cfg);
        slot[1]  = mask_zm((en_a && en_b) ? cand_b : cand_c, r_cfg);
        slot[2]  = mask_zm(cand_c, r_cfg);
        slot_cnt = {1'b0, en_a} + {1'b0, en_b} + {1'b0, en_c};
        slot_last = '0;
        unique case (slot_cnt)
            2'd1:    slot_last[0] = eol;
            2'd2:    slot_last[1] = eol;
            2'd3:    slot_last[2] = eol;
            default: slot_last    = '0;
        endcase
    end

    ccp_outq #(
        .W (W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_pts   (slot),
        .i_last  (slot_last),
        .i_cnt   (slot_cnt),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_pt    (q_pt),
        .o_last  (o_m_tlast),
        .o_stat  (q_stat)
    );

    assign o_m_tdata = TDATA_W'(q_pt);

    // polyline state
    always_comb begin
        n_have_prev   = r_have_prev;
        n_prev_first  = r_prev_first;
        n_first_valid = r_first_valid;
        if (accept) begin
            if (eol) begin
                n_have_prev   = 1'b0;
                n_prev_first  = 1'b0;
                n_first_valid = 1'b0;
            end else begin
                n_have_prev   = 1'b1;
                n_prev_first  = !r_have_prev;
                n_first_valid = r_have_prev && (r_first_valid || en_a);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '{keep_endpoints: 1'b1, close_ring: 1'b0,
                               use_z: 1'b0, use_m: 1'b0};
            r_have_prev   <= 1'b0;
            r_prev_first  <= 1'b0;
            r_first_valid <= 1'b0;
        end else begin
            r_cfg         <= n_cfg;
            r_have_prev   <= n_have_prev;
            r_prev_first  <= n_prev_first;
            r_first_valid <= n_first_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !eol) begin
            r_prev <= cur;
        end
        if (accept && r_have_prev && en_a && !r_first_valid) begin
            r_first <= cut1;
        end
    end

    `CCP_ASSERT_NOW(a_first_needs_prev, r_first_valid, r_have_prev,
        "first emitted point recorded without an open polyline")
    `CCP_ASSERT_NOW(a_pfirst_needs_prev, r_prev_first, r_have_prev,
        "previous-is-first set without a previous point")
    `CCP_ASSERT_NEXT(a_eol_closes, accept && eol, !r_have_prev,
        "polyline still open after its last point")
    `CCP_ASSERT_NOW(a_no_overrun, accept, q_stat.count <= 2'd1,
        "request taken while results still queued")
    `CCP_ASSERT_NEXT(a_drain_empties,
        o_m_tvalid && i_m_tready && (q_stat.count == 2'd1) && !accept,
        !o_m_tvalid, "result queue not empty after draining its last entry")

endmodule
